// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level of the Hamming encoder and checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsec assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsec assertion failed");

`endif

// File: rtl/hsec_pkg.sv
// Package of the Hamming encoder and checker: codes, widths and code layout functions.
package hsec_pkg;

    localparam int MAX_CODE_BITS   = 64;
    localparam int WORD_W          = 64;
    localparam int CFG_W           = 6;
    localparam int SYN_W           = 7;
    localparam int DATA_BITS_RESET = 4;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    // Least k with 2^k >= n + k + 1, for n from 1 up to 120.
    function automatic logic [2:0] parity_count(input logic [6:0] n);
        logic [2:0] k;
        k = 3'd7;
        for (int j = 6; j >= 1; j--)
        begin
            if ((8'd1 << j) >= (8'(n) + 8'(j) + 8'd1))
            begin
                k = 3'(j);
            end
        end
        return k;
    endfunction

    // Largest data width whose codeword fits in max_code positions.
    function automatic int max_data_bits(input int max_code);
        int best;
        best = 1;
        for (int n = 1; n < (1 << CFG_W); n++)
        begin
            if (n + int'(parity_count(7'(n))) <= max_code)
            begin
                best = n;
            end
        end
        return best;
    endfunction

    function automatic int code_length(input int n);
        return n + int'(parity_count(7'(n)));
    endfunction

    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Data bit carried at codeword position p (p not a power of two).
    function automatic int data_index(input int p);
        int pows;
        pows = 0;
        for (int j = 0; j < SYN_W; j++)
        begin
            if ((1 << j) <= p)
            begin
                pows++;
            end
        end
        return p - 1 - pows;
    endfunction

    // Word bits whose position has syndrome bit j set.
    function automatic logic [WORD_W-1:0] syndrome_select(input int j);
        logic [WORD_W-1:0] sel;
        sel = '0;
        for (int p = 1; p <= WORD_W; p++)
        begin
            sel[p-1] = ((p >> j) & 1) != 0;
        end
        return sel;
    endfunction

endpackage

// File: rtl/hsec_syndrome.sv
// Syndrome of a codeword: XOR of the positions of all set bits, as parallel XOR trees.
module hsec_syndrome #(
    parameter int MAX_CODE_BITS = hsec_pkg::MAX_CODE_BITS
) (
    input  logic [MAX_CODE_BITS-1:0]     cw,
    output logic [hsec_pkg::SYN_W-1:0]   syn
);

    for (genvar j = 0; j < hsec_pkg::SYN_W; j++)
    begin : g_bit
        localparam logic [hsec_pkg::WORD_W-1:0] SEL = hsec_pkg::syndrome_select(j);
        assign syn[j] = ^(cw & SEL[MAX_CODE_BITS-1:0]);
    end

endmodule

// File: rtl/hamming_sec_encode_check.sv
// Top level of the Hamming single-error-correcting encoder and checker, three-stage pipeline.
//
// One item enters per clock cycle and busy never rises, so start may be held high
// continuously. Each result is on the result ports for exactly one cycle, marked by strobe:
// stage one scatters or masks the word, stage two forms the syndrome, stage three fills in
// parity or flips the named bit. The receiver cannot stall, and results leave in the order
// items came in. A write to data_bits sets the code layout for items taken from the next
// cycle on; the derived codeword length is registered at the write, so the write should
// happen with no item in flight. Reset selects four data bits, a seven-bit codeword.
`include "assert_macros.svh"

module hamming_sec_encode_check #(
    parameter int MAX_CODE_BITS = hsec_pkg::MAX_CODE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [hsec_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [hsec_pkg::WORD_W-1:0]   word,
    output logic                          strobe,
    output logic [hsec_pkg::WORD_W-1:0]   codeword,
    output logic [hsec_pkg::SYN_W-1:0]    error_position,
    output logic                          error_found,
    output logic                          uncorrectable
);

    localparam int W     = MAX_CODE_BITS;
    localparam int SYN_W = hsec_pkg::SYN_W;
    localparam int MAX_N = hsec_pkg::max_data_bits(W);
    localparam int RESET_N =
        (hsec_pkg::DATA_BITS_RESET > MAX_N) ? MAX_N : hsec_pkg::DATA_BITS_RESET;
    localparam logic [SYN_W-1:0] RESET_TOTAL = SYN_W'(hsec_pkg::code_length(RESET_N));

    // ---------------- configuration ----------------
    logic [SYN_W-1:0] total_reg, total_next;
    logic [SYN_W-1:0] cfg_n;
    logic [W-1:0]     len_mask;

    always_comb
    begin
        cfg_n = SYN_W'(cfg_write_data);
        if (cfg_n == '0)
        begin
            cfg_n = SYN_W'(1);
        end
        if (cfg_n > SYN_W'(MAX_N))
        begin
            cfg_n = SYN_W'(MAX_N);
        end
        total_next = total_reg;
        if (cfg_write_en)
        begin
            total_next = cfg_n + SYN_W'(hsec_pkg::parity_count(cfg_n));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= RESET_TOTAL;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            len_mask[i] = SYN_W'(i) < total_reg;
        end
    end

    assign busy = 1'b0;

    // ---------------- stage 1: scatter or mask ----------------
    logic [W-1:0] scatter;
    logic         s1_valid_reg;
    logic         s1_kind_reg;
    logic [W-1:0] s1_cw_reg, s1_cw_next;

    for (genvar p = 1; p <= W; p++)
    begin : g_scatter
        if (hsec_pkg::is_pow2(p))
        begin : g_par
            assign scatter[p-1] = 1'b0;
        end
        else
        begin : g_dat
            assign scatter[p-1] = word[hsec_pkg::data_index(p)];
        end
    end

    always_comb
    begin
        if (kind == hsec_pkg::KIND_CHECK)
        begin
            s1_cw_next = word[W-1:0] & len_mask;
        end
        else
        begin
            // Data bits beyond n land beyond the length and drop out here.
            s1_cw_next = scatter & len_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= kind;
        s1_cw_reg   <= s1_cw_next;
    end

    // ---------------- stage 2: syndrome ----------------
    logic [SYN_W-1:0] s2_syn_next;
    logic             s2_valid_reg;
    logic             s2_kind_reg;
    logic [W-1:0]     s2_cw_reg;
    logic [SYN_W-1:0] s2_syn_reg;

    hsec_syndrome #(
        .MAX_CODE_BITS (W)
    ) u_syndrome (
        .cw  (s1_cw_reg),
        .syn (s2_syn_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_kind_reg <= s1_kind_reg;
        s2_cw_reg   <= s1_cw_reg;
        s2_syn_reg  <= s2_syn_next;
    end

    // ---------------- stage 3: parity fill or correction ----------------
    logic [W-1:0]     parity_bits;
    logic [W-1:0]     flip_bits;
    logic [W-1:0]     out_cw_next;
    logic             syn_nonzero;
    logic             syn_in_range;
    logic             strobe_reg;
    logic [W-1:0]     codeword_reg;
    logic [SYN_W-1:0] error_position_reg, error_position_next;
    logic             error_found_reg, error_found_next;
    logic             uncorrectable_reg, uncorrectable_next;

    always_comb
    begin
        parity_bits = '0;
        for (int j = 0; j < SYN_W; j++)
        begin
            if ((1 << j) <= W)
            begin
                parity_bits[(1 << j) - 1] = s2_syn_reg[j];
            end
        end
        for (int i = 0; i < W; i++)
        begin
            flip_bits[i] = s2_syn_reg == SYN_W'(i + 1);
        end
        syn_nonzero  = s2_syn_reg != '0;
        syn_in_range = s2_syn_reg <= total_reg;

        if (s2_kind_reg == hsec_pkg::KIND_CHECK)
        begin
            // Drop a flip that points past the codeword length; the word passes unchanged.
            out_cw_next         = s2_cw_reg ^ (flip_bits & len_mask);
            error_position_next = s2_syn_reg;
            error_found_next    = syn_nonzero;
            uncorrectable_next  = syn_nonzero && !syn_in_range;
        end
        else
        begin
            out_cw_next         = s2_cw_reg | parity_bits;
            error_position_next = '0;
            error_found_next    = 1'b0;
            uncorrectable_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        codeword_reg       <= out_cw_next;
        error_position_reg <= error_position_next;
        error_found_reg    <= error_found_next;
        uncorrectable_reg  <= uncorrectable_next;
    end

    assign strobe         = strobe_reg;
    assign codeword       = hsec_pkg::WORD_W'(codeword_reg);
    assign error_position = error_position_reg;
    assign error_found    = error_found_reg;
    assign uncorrectable  = uncorrectable_reg;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_item_reaches_output, s2_valid_reg, strobe)
    `ASSERT_IMPLIES(a_unc_has_error, strobe && uncorrectable, error_found)
    `ASSERT_IMPLIES(a_clean_no_position, strobe && !error_found, error_position == '0)
    `ASSERT_IMPLIES(a_fixed_in_range, strobe && error_found && !uncorrectable,
                    error_position <= total_reg)
    `ASSERT_IMPLIES(a_no_bits_past_length, strobe, (codeword_reg & ~len_mask) == '0)

endmodule

// File: sim/hsec_checker.sv
// Checker for the Hamming encoder and checker: predicts every result and compares it.
module hsec_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [hsec_pkg::CFG_W-1:0]      cfg_write_data,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            kind,
    input  logic [hsec_pkg::WORD_W-1:0]     word,
    input  logic                            strobe,
    input  logic [hsec_pkg::WORD_W-1:0]     codeword,
    input  logic [hsec_pkg::SYN_W-1:0]      error_position,
    input  logic                            error_found,
    input  logic                            uncorrectable,
    output int                              fail_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam int WORD_W       = hsec_pkg::WORD_W;
    localparam int SYN_W        = hsec_pkg::SYN_W;
    localparam int CFG_W        = hsec_pkg::CFG_W;

    typedef struct packed {
        logic [WORD_W-1:0] codeword;
        logic [SYN_W-1:0]  error_position;
        logic              error_found;
        logic              uncorrectable;
    } hamming_result_t;

    hamming_result_t  expected_results[$];
    hamming_result_t  golden;
    hamming_result_t  observed;
    logic [CFG_W-1:0] data_bits_q;

    function automatic int parity_width(input int n);
        int k;
        k = 0;
        while ((1 << k) < n + k + 1)
        begin
            k++;
        end
        return k;
    endfunction

    // Zero acts as one; oversize widths shrink until the codeword fits.
    function automatic int usable_data_bits(input logic [CFG_W-1:0] setting);
        int n;
        n = int'(setting);
        if (n == 0)
        begin
            n = 1;
        end
        while (n > 1 && n + parity_width(n) > hsec_pkg::MAX_CODE_BITS)
        begin
            n--;
        end
        return n;
    endfunction

    function automatic int position_syndrome(input logic [WORD_W-1:0] cw, input int total);
        int syn;
        syn = 0;
        for (int p = 1; p <= total; p++)
        begin
            if (cw[p-1])
            begin
                syn ^= p;
            end
        end
        return syn;
    endfunction

    function automatic hamming_result_t predict_hamming(input logic op,
                                                        input logic [WORD_W-1:0] w,
                                                        input logic [CFG_W-1:0] setting);
        hamming_result_t r;
        int n;
        int k;
        int total;
        int syn;
        int d;
        logic [WORD_W-1:0] mask;
        n = usable_data_bits(setting);
        k = parity_width(n);
        total = n + k;
        mask = (total >= WORD_W) ? '1 : ((64'd1 << total) - 64'd1);
        r = '0;
        if (op == hsec_pkg::KIND_ENCODE)
        begin
            // scatter data into the positions that are not powers of two
            d = 0;
            for (int p = 1; p <= total; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    if (w[d])
                    begin
                        r.codeword[p-1] = 1'b1;
                    end
                    d++;
                end
            end
            syn = position_syndrome(r.codeword, total);
            for (int j = 0; j < k; j++)
            begin
                if (((syn >> j) & 1) != 0 && (1 << j) <= total)
                begin
                    r.codeword[(1 << j) - 1] = 1'b1;
                end
            end
        end
        else
        begin
            r.codeword = w & mask;
            syn = position_syndrome(r.codeword, total);
            if (syn != 0)
            begin
                r.error_found = 1'b1;
                r.error_position = syn[SYN_W-1:0];
                if (syn <= total)
                begin
                    r.codeword[syn-1] = ~r.codeword[syn-1];
                end
                else
                begin
                    r.uncorrectable = 1'b1;
                end
            end
        end
        r.codeword &= mask;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            data_bits_q = CFG_W'(hsec_pkg::DATA_BITS_RESET);
        end
        else
        begin
            if (strobe)
            begin
                observed = {codeword, error_position, error_found, uncorrectable};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("ERROR: result with no item outstanding: codeword %h pos %0d",
                                 codeword, error_position);
                    end
                end
                else
                begin
                    golden = expected_results.pop_front();
                    if (observed.codeword !== golden.codeword
                        || observed.error_position !== golden.error_position
                        || observed.error_found !== golden.error_found
                        || observed.uncorrectable !== golden.uncorrectable)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("ERROR: expected cw %h pos %0d found %b unc %b",
                                     golden.codeword, golden.error_position,
                                     golden.error_found, golden.uncorrectable);
                            $display("       actual   cw %h pos %0d found %b unc %b",
                                     observed.codeword, observed.error_position,
                                     observed.error_found, observed.uncorrectable);
                        end
                    end
                end
            end
            // predict with the width in force before any write at this edge
            if (start && !busy)
            begin
                expected_results.push_back(predict_hamming(kind, word, data_bits_q));
            end
            if (cfg_write_en)
            begin
                data_bits_q = cfg_write_data;
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// File: sim/tb_top.sv
// Top of the Hamming encoder and checker testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_COUNT  = 15;
    localparam int POOL_DEPTH   = 16;
    localparam int WORD_W       = hsec_pkg::WORD_W;
    localparam int SYN_W        = hsec_pkg::SYN_W;
    localparam int CFG_W        = hsec_pkg::CFG_W;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [CFG_W-1:0]    cfg_write_data;
    logic                start;
    logic                busy;
    logic                kind;
    logic [WORD_W-1:0]   word;
    logic                strobe;
    logic [WORD_W-1:0]   codeword;
    logic [SYN_W-1:0]    error_position;
    logic                error_found;
    logic                uncorrectable;
    int                  fail_count;
    int                  pending_count;

    logic [WORD_W-1:0]   recent_codewords[POOL_DEPTH];
    int                  recent_fill = 0;
    int                  recent_next = 0;
    int                  code_span;
    bit                  idle_enabled;

    hamming_sec_encode_check dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .word           (word),
        .strobe         (strobe),
        .codeword       (codeword),
        .error_position (error_position),
        .error_found    (error_found),
        .uncorrectable  (uncorrectable)
    );

    hsec_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .word           (word),
        .strobe         (strobe),
        .codeword       (codeword),
        .error_position (error_position),
        .error_found    (error_found),
        .uncorrectable  (uncorrectable),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Keep recent codewords from the block to feed back as check items.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            recent_codewords[recent_next] <= codeword;
            recent_next <= (recent_next + 1) % POOL_DEPTH;
            if (recent_fill < POOL_DEPTH)
            begin
                recent_fill <= recent_fill + 1;
            end
        end
    end

    function automatic logic [CFG_W-1:0] phase_setting(input int ph);
        case (ph)
            0:       return CFG_W'(0);
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'(3);
            4:       return CFG_W'(hsec_pkg::DATA_BITS_RESET);
            5:       return CFG_W'(5);
            6:       return CFG_W'(11);
            7:       return CFG_W'(26);
            8:       return CFG_W'(57);
            9:       return CFG_W'(58);
            10:      return CFG_W'(63);
            default: return CFG_W'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic apply_item(input logic op, input logic [WORD_W-1:0] w);
        bit taken;
        while (idle_enabled && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            kind <= 1'($urandom_range(0, 1));
            word <= {$urandom, $urandom};
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= op;
        word <= w;
        // busy only moves at the rising edge, so sample it in the low phase
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_count != 0);
        @(posedge clk);
    endtask

    task automatic write_data_bits(input logic [CFG_W-1:0] value);
        int n;
        start <= 1'b0;
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        // rough codeword span, used to aim bit flips and to place junk bits above the codeword
        n = (value == 0) ? 1 : ((value > 57) ? 57 : int'(value));
        code_span = (n + 6 > WORD_W) ? WORD_W : n + 6;
    endtask

    task automatic random_item();
        logic [WORD_W-1:0] w;
        int choice;
        choice = $urandom_range(0, 99);
        w = {$urandom, $urandom};
        if (choice < 40)
        begin
            case ($urandom_range(0, 9))
                0:       w = '0;
                1:       w = '1;
                2:       w = 64'd1 << $urandom_range(0, WORD_W - 1);
                default: ;
            endcase
            apply_item(hsec_pkg::KIND_ENCODE, w);
        end
        else if (choice < 90 && recent_fill > 0)
        begin
            w = recent_codewords[$urandom_range(0, recent_fill - 1)];
            if ($urandom_range(0, 2) != 0)
            begin
                w[$urandom_range(0, code_span - 1)] ^= 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                w |= {$urandom, $urandom} << code_span;
            end
            apply_item(hsec_pkg::KIND_CHECK, w);
        end
        else
        begin
            apply_item(hsec_pkg::KIND_CHECK, w);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = hsec_pkg::KIND_ENCODE;
        word = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        idle_enabled = 1'b1;
        code_span = 10;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width: four data bits, seven-bit codeword
        apply_item(hsec_pkg::KIND_ENCODE, '0);
        apply_item(hsec_pkg::KIND_ENCODE, 64'hF);
        apply_item(hsec_pkg::KIND_ENCODE, '1);
        apply_item(hsec_pkg::KIND_ENCODE, 64'h5);
        apply_item(hsec_pkg::KIND_ENCODE, 64'h1);
        apply_item(hsec_pkg::KIND_CHECK, '0);
        apply_item(hsec_pkg::KIND_CHECK, '1);
        for (int i = 0; i < 7; i++)
        begin
            apply_item(hsec_pkg::KIND_CHECK, 64'd1 << i);
        end

        // two data bits: syndromes six and seven point past the codeword
        write_data_bits(CFG_W'(2));
        apply_item(hsec_pkg::KIND_CHECK, 64'hA);
        apply_item(hsec_pkg::KIND_CHECK, 64'hB);
        apply_item(hsec_pkg::KIND_CHECK, 64'h10);
        apply_item(hsec_pkg::KIND_ENCODE, 64'h3);

        // widest code
        write_data_bits(CFG_W'(57));
        apply_item(hsec_pkg::KIND_ENCODE, '1);
        apply_item(hsec_pkg::KIND_ENCODE, 64'h0100_0000_0000_0000);
        apply_item(hsec_pkg::KIND_CHECK, '1);
        apply_item(hsec_pkg::KIND_CHECK, 64'h4000_0000_0000_0000);

        // zero width acts as one data bit
        write_data_bits(CFG_W'(0));
        apply_item(hsec_pkg::KIND_ENCODE, 64'h1);
        apply_item(hsec_pkg::KIND_CHECK, 64'h4);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_data_bits(phase_setting(ph));
            idle_enabled = (ph != 7);
            repeat (RANDOM_ITEMS / PHASE_COUNT) random_item();
        end

        start <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("PASS hamming_sec_encode_check");
        end
        else
        begin
            $display("FAIL hamming_sec_encode_check");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL hamming_sec_encode_check");
        $finish;
    end

endmodule
